// ----- sv/tfsc_pkg.sv -----
// ----------------------------------------------------------------------------
// tfsc_pkg: shared types and constants
// Phase codes, poll/result payloads, configuration and state records.
// ----------------------------------------------------------------------------
package tfsc_pkg;

	// Nodes that may own a bit in the presence bitmap
	localparam int NODE_COUNT = 8;

	localparam int CFG_AW = 4;

	// Register indexes (byte address / 4)
	localparam logic [1:0] REG_OWN_ID   = 2'd0;
	localparam logic [1:0] REG_TRUNK_ID = 2'd1;
	localparam logic [1:0] REG_SLOT_US  = 2'd2;
	localparam logic [1:0] REG_FRAME_US = 2'd3;

	localparam logic [2:0]  OWN_ID_RESET   = 3'd1;
	localparam logic [2:0]  TRUNK_ID_RESET = 3'd4;
	localparam logic [15:0] SLOT_US_RESET  = 16'd660;
	localparam logic [15:0] FRAME_US_RESET = 16'd10000;

	// Motor link status codes (3 reads as busy)
	localparam logic [1:0] MST_WAIT_NEXT = 2'd1;
	localparam logic [1:0] MST_DONE      = 2'd2;

	// Motor link call codes
	localparam logic [1:0] MSTEP_NONE    = 2'd0;
	localparam logic [1:0] MSTEP_NO_TICK = 2'd1;
	localparam logic [1:0] MSTEP_TICK    = 2'd2;

	typedef enum logic [3:0] {
		PH_INIT      = 4'd0,
		PH_SEARCH    = 4'd1,
		PH_SYNCED    = 4'd2,
		PH_RX        = 4'd3,
		PH_TX        = 4'd4,
		PH_RX2       = 4'd5,
		PH_MOTOR     = 4'd6,
		PH_IDLE      = 4'd7,
		PH_LOCKOUT   = 4'd8,
		PH_WAIT_SYNC = 4'd9
	} phase_t;

	typedef struct packed {
		logic       slot_valid;
		logic [2:0] slot_node;
		logic       send_tick;
		logic       sync_tick;
		logic       motor_tick;
		logic [1:0] motor_status;
		logic       passthrough_ready;
	} poll_t;

	typedef struct packed {
		logic [3:0]  phase;
		logic        sync_restart;
		logic [19:0] sync_period_us;
		logic        send_own_slot;
		logic [2:0]  leader_node;
		logic [7:0]  nodes_seen_last;
		logic [7:0]  frame_count;
		logic [7:0]  passthrough_count;
		logic        forward_slot;
		logic        motor_prepare;
		logic [1:0]  motor_step;
	} result_t;

	typedef struct packed {
		logic [2:0]  own_id;
		logic [2:0]  trunk_node_id;
		logic [15:0] slot_time_us;
		logic [15:0] frame_time_us;
	} cfg_t;

	typedef struct packed {
		phase_t     phase;
		logic [2:0] leading_node;
		logic [7:0] nodes_seen;
		logic [7:0] nodes_seen_prev;
		logic       sync_armed;
		logic [7:0] frames;
		logic [7:0] pt_transfers;
		logic       sync_pending;
		logic       send_pending;
		logic       motor_pending;
	} state_t;

	// Presence bit of a node; ids past the node count set nothing
	function automatic logic [7:0] node_bit(input logic [2:0] id);
		node_bit = ({29'd0, id} < 32'(NODE_COUNT)) ? (8'd1 << id) : 8'd0;
	endfunction

endpackage

// ----- sv/tfsc_stream_if.sv -----
// ----------------------------------------------------------------------------
// tfsc_stream_if: valid/ready channels
// Poll channel into the controller and result channel out of it.
// ----------------------------------------------------------------------------
interface tfsc_poll_if;
	logic            valid;
	logic            ready;
	tfsc_pkg::poll_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface tfsc_result_if;
	logic              valid;
	logic              ready;
	tfsc_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/tfsc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// tfsc_cfg_regs: APB configuration registers
// Own id, trunk id, slot and frame durations; zero wait states.
// ----------------------------------------------------------------------------
module tfsc_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tfsc_pkg::CFG_AW-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output tfsc_pkg::cfg_t              cfg
);

	logic [2:0]  own_id_q;
	logic [2:0]  trunk_id_q;
	logic [15:0] slot_us_q;
	logic [15:0] frame_us_q;
	logic [1:0]  idx;
	logic        wr;

	assign idx    = paddr[3:2];
	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q   <= tfsc_pkg::OWN_ID_RESET;
			trunk_id_q <= tfsc_pkg::TRUNK_ID_RESET;
			slot_us_q  <= tfsc_pkg::SLOT_US_RESET;
			frame_us_q <= tfsc_pkg::FRAME_US_RESET;
		end else if (wr) begin
			unique case (idx)
				tfsc_pkg::REG_OWN_ID:   own_id_q   <= pwdata[2:0];
				tfsc_pkg::REG_TRUNK_ID: trunk_id_q <= pwdata[2:0];
				tfsc_pkg::REG_SLOT_US:  slot_us_q  <= pwdata[15:0];
				tfsc_pkg::REG_FRAME_US: frame_us_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			tfsc_pkg::REG_OWN_ID:   prdata = {29'd0, own_id_q};
			tfsc_pkg::REG_TRUNK_ID: prdata = {29'd0, trunk_id_q};
			tfsc_pkg::REG_SLOT_US:  prdata = {16'd0, slot_us_q};
			tfsc_pkg::REG_FRAME_US: prdata = {16'd0, frame_us_q};
			default:                prdata = 32'd0;
		endcase
	end

	assign cfg.own_id        = own_id_q;
	assign cfg.trunk_node_id = trunk_id_q;
	assign cfg.slot_time_us  = slot_us_q;
	assign cfg.frame_time_us = frame_us_q;

endmodule

// ----- sv/tfsc_step.sv -----
// ----------------------------------------------------------------------------
// tfsc_step: phase logic for one poll
// Next controller state and the result record, from state, poll and config.
// ----------------------------------------------------------------------------
module tfsc_step (
	input  tfsc_pkg::cfg_t    cfg,
	input  tfsc_pkg::state_t  st,
	input  tfsc_pkg::poll_t   item,
	output tfsc_pkg::state_t  st_nx,
	output tfsc_pkg::result_t res
);

	logic        trunk;
	logic        use_slot_id;
	logic        use_tenfold;
	logic [2:0]  per_id;
	logic [18:0] offset;
	logic [15:0] per_short;
	logic [19:0] tenfold;
	logic [19:0] period;
	logic        restart;
	logic        send;
	logic        fwd;
	logic        mprep;
	logic [1:0]  mstep;
	logic [2:0]  lead_min;

	assign trunk = (cfg.own_id == cfg.trunk_node_id);

	// One shared id*slot product feeds the slot period requests; init uses ten frames
	assign per_id    = use_slot_id ? item.slot_node : cfg.own_id;
	assign offset    = {16'd0, per_id} * {3'd0, cfg.slot_time_us};
	assign per_short = (offset >= {3'd0, cfg.frame_time_us}) ? 16'd0
		: (cfg.frame_time_us - offset[15:0]);
	assign tenfold   = {1'b0, cfg.frame_time_us, 3'd0} + {3'd0, cfg.frame_time_us, 1'b0};
	assign period    = use_tenfold ? tenfold : {4'd0, per_short};

	assign lead_min  = (item.slot_node < st.leading_node) ? item.slot_node : st.leading_node;

	always_comb begin
		st_nx = st;
		st_nx.sync_pending  = st.sync_pending  | item.sync_tick;
		st_nx.send_pending  = st.send_pending  | item.send_tick;
		st_nx.motor_pending = st.motor_pending | item.motor_tick;
		restart     = 1'b0;
		use_slot_id = 1'b0;
		use_tenfold = 1'b0;
		send        = 1'b0;
		fwd         = 1'b0;
		mprep       = 1'b0;
		mstep       = tfsc_pkg::MSTEP_NONE;

		unique case (st.phase)
			tfsc_pkg::PH_INIT: begin
				st_nx.phase        = tfsc_pkg::PH_SEARCH;
				restart            = 1'b1;
				use_tenfold        = 1'b1;
				st_nx.leading_node = cfg.own_id;
			end
			tfsc_pkg::PH_SEARCH: begin
				if (item.slot_valid) begin
					restart            = 1'b1;
					use_slot_id        = 1'b1;
					st_nx.leading_node = item.slot_node;
					// sync already latched: skip the wait
					if (st_nx.sync_pending) begin
						st_nx.sync_pending = 1'b0;
						st_nx.phase        = tfsc_pkg::PH_SYNCED;
					end else begin
						st_nx.phase = tfsc_pkg::PH_WAIT_SYNC;
					end
				end else if (st_nx.sync_pending) begin
					st_nx.sync_pending = 1'b0;
					restart            = 1'b1;
					st_nx.phase        = tfsc_pkg::PH_SYNCED;
				end
			end
			tfsc_pkg::PH_WAIT_SYNC: begin
				if (st_nx.sync_pending) begin
					st_nx.sync_pending = 1'b0;
					st_nx.phase        = tfsc_pkg::PH_SYNCED;
				end
			end
			tfsc_pkg::PH_SYNCED: begin
				st_nx.frames          = st.frames + 8'd1;
				st_nx.phase           = tfsc_pkg::PH_RX;
				st_nx.leading_node    = cfg.own_id;
				st_nx.nodes_seen_prev = st.nodes_seen;
				st_nx.nodes_seen      = tfsc_pkg::node_bit(cfg.own_id);
				st_nx.sync_armed      = 1'b0;
			end
			tfsc_pkg::PH_RX: begin
				if (item.slot_valid) begin
					st_nx.nodes_seen   = st.nodes_seen | tfsc_pkg::node_bit(item.slot_node);
					st_nx.leading_node = lead_min;
					if (lead_min != cfg.own_id && !st.sync_armed
							&& item.slot_node == lead_min) begin
						restart          = 1'b1;
						use_slot_id      = 1'b1;
						st_nx.sync_armed = 1'b1;
					end
					if (item.slot_node == cfg.own_id) st_nx.phase = tfsc_pkg::PH_LOCKOUT;
					fwd = trunk;
				end
				// own slot due wins over a duplicate id
				if (st_nx.send_pending) begin
					st_nx.send_pending = 1'b0;
					st_nx.phase        = tfsc_pkg::PH_TX;
				end
			end
			tfsc_pkg::PH_TX: begin
				send = 1'b1;
				if (st.leading_node == cfg.own_id) begin
					restart          = 1'b1;
					st_nx.sync_armed = 1'b1;
				end
				fwd         = trunk;
				st_nx.phase = tfsc_pkg::PH_RX2;
			end
			tfsc_pkg::PH_RX2: begin
				if (!st.sync_armed) st_nx.phase = tfsc_pkg::PH_INIT;
				if (item.slot_valid) begin
					st_nx.nodes_seen = st.nodes_seen | tfsc_pkg::node_bit(item.slot_node);
					fwd              = trunk;
				end
				if (trunk && item.passthrough_ready) st_nx.pt_transfers = st.pt_transfers + 8'd1;
				if (st_nx.motor_pending) begin
					st_nx.phase         = tfsc_pkg::PH_MOTOR;
					st_nx.motor_pending = 1'b0;
					mprep               = 1'b1;
				end
			end
			tfsc_pkg::PH_MOTOR: begin
				mstep = st_nx.motor_pending ? tfsc_pkg::MSTEP_TICK : tfsc_pkg::MSTEP_NO_TICK;
				if (item.motor_status == tfsc_pkg::MST_DONE) begin
					st_nx.phase         = tfsc_pkg::PH_IDLE;
					st_nx.motor_pending = 1'b0;
				end else if (item.motor_status == tfsc_pkg::MST_WAIT_NEXT) begin
					st_nx.motor_pending = 1'b0;
				end
			end
			tfsc_pkg::PH_IDLE: begin
				if (st_nx.sync_pending) begin
					st_nx.phase        = tfsc_pkg::PH_SYNCED;
					st_nx.sync_pending = 1'b0;
				end
			end
			default: st_nx.phase = tfsc_pkg::PH_LOCKOUT;
		endcase
	end

	always_comb begin
		res.phase             = st_nx.phase;
		res.sync_restart      = restart;
		res.sync_period_us    = restart ? period : 20'd0;
		res.send_own_slot     = send;
		res.leader_node       = st_nx.leading_node;
		res.nodes_seen_last   = st_nx.nodes_seen_prev;
		res.frame_count       = st_nx.frames;
		res.passthrough_count = st_nx.pt_transfers;
		res.forward_slot      = fwd;
		res.motor_prepare     = mprep;
		res.motor_step        = mstep;
	end

endmodule

// ----- sv/tdma_frame_sync_controller.sv -----
// ----------------------------------------------------------------------------
// tdma_frame_sync_controller: slotted-bus frame sync controller
// Phase sequencer, leader tracking and presence bitmap for one bus node.
// ----------------------------------------------------------------------------
// Usage:
//  - poll (sink): one request per bus poll, valid/ready; carries latched timer
//    ticks, received slot id, motor link status and pass-through flag.
//  - result (source): one result per poll, in order; phase, sync timer
//    restart request with period, own-slot send request, forwarding, motor calls.
//  - APB port: own id, trunk id, slot and frame time at byte offsets 0/4/8/12;
//    zero wait states. Write only while no poll is in flight.
// Path: a poll is registered in the input register at acceptance, the step
//   logic works on it there, and its result is loaded into the output register
//   when that register is free or being taken, together with the new state.
//   Throughput: one poll per clock while result.ready stays high; the single
//   id*slot multiply and the phase decision sit between the two registers.
// Reset: phase init, leader = own id reset value, bitmaps, counters and
//   pending ticks cleared; registers take their defaults.
// Stall: while result.ready is low the result holds, one more poll waits in
//   the input register and poll.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module tdma_frame_sync_controller (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tfsc_pkg::CFG_AW-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	tfsc_poll_if.sink                   poll,
	tfsc_result_if.source               result
);

	tfsc_pkg::cfg_t    cfg;
	tfsc_pkg::state_t  state_q;
	tfsc_pkg::state_t  state_nx;
	tfsc_pkg::poll_t   poll_s1;
	tfsc_pkg::result_t res_nx;
	tfsc_pkg::result_t res_s2;
	logic              valid_s1;
	logic              valid_s2;
	logic              advance;
	logic              accept;

	tfsc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tfsc_step u_step (
		.cfg   (cfg),
		.st    (state_q),
		.item  (poll_s1),
		.st_nx (state_nx),
		.res   (res_nx)
	);

	// Poll in stage 1 moves on when the result register is free or drains now
	assign advance    = valid_s1 & (~valid_s2 | result.ready);
	assign poll.ready = ~valid_s1 | advance;
	assign accept     = poll.valid & poll.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			poll_s1 <= poll.data;
		end
	end

	// Controller state commits together with the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase           <= tfsc_pkg::PH_INIT;
			state_q.leading_node    <= tfsc_pkg::OWN_ID_RESET;
			state_q.nodes_seen      <= 8'd0;
			state_q.nodes_seen_prev <= 8'd0;
			state_q.sync_armed      <= 1'b0;
			state_q.frames          <= 8'd0;
			state_q.pt_transfers    <= 8'd0;
			state_q.sync_pending    <= 1'b0;
			state_q.send_pending    <= 1'b0;
			state_q.motor_pending   <= 1'b0;
			valid_s2                <= 1'b0;
		end else if (advance) begin
			state_q  <= state_nx;
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nx;
		end
	end

	assign result.valid = valid_s2;
	assign result.data  = res_s2;

	// Period field only carries a value with a restart request
	a_period_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !res_s2.sync_restart |-> res_s2.sync_period_us == 20'd0)
		else $error("sync period set without restart");

	// Own slot is sent only on the transmit step, which always enters receive 2
	a_send_phase: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.send_own_slot |-> res_s2.phase == tfsc_pkg::PH_RX2)
		else $error("send request outside transmit step");

	a_mprep_phase: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.motor_prepare |-> res_s2.phase == tfsc_pkg::PH_MOTOR)
		else $error("motor prepare without motor write phase");

	// Empty result register never blocks the poll channel
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> poll.ready)
		else $error("poll stalled with free result register");

	// Frame counter steps by one, only when entering receive
	a_frame_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance && state_nx.frames != state_q.frames
			|-> state_nx.frames == state_q.frames + 8'd1 && state_nx.phase == tfsc_pkg::PH_RX)
		else $error("frame counter jumped");

endmodule
